>>> rtl/isrt_pkg.sv
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared constants, types and register codes for the radix text converter.
// ----------------------------------------------------------------------------
package isrt_pkg;

    localparam int MAX_SYMBOLS_DEFAULT  = 16;
    localparam int NUMBER_WIDTH_DEFAULT = 32;

    localparam int BASE_W     = 5;
    localparam int ALPHABET_W = 128;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;
    localparam int STEP_BITS  = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        REG_BASE_LENGTH   = 2'd0,
        REG_ALPHABET_LOW  = 2'd1,
        REG_ALPHABET_HIGH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [BASE_W-1:0]     base_length;
        logic [ALPHABET_W-1:0] alphabet;
    } cfg_t;

    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_INVALID,
        BACK_DIVIDE,
        BACK_SIGN,
        BACK_EMIT
    } back_state_t;

endpackage

>>> rtl/isrt_if.sv
// ----------------------------------------------------------------------------
// isrt_if
// Valid/ready channels for numbers in and characters out.
// ----------------------------------------------------------------------------
interface isrt_in_if #(
    parameter int NUMBER_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [NUMBER_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface isrt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;
    logic       invalid_base;

    modport source (output valid, output symbol, output last, output invalid_base,
                    input ready);
    modport sink   (input valid, input symbol, input last, input invalid_base,
                    output ready);
endinterface

>>> rtl/signed_integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Writes signed numbers as text in a configurable alphabet and radix.
// ----------------------------------------------------------------------------
// Each accepted number yields one character word per symbol, a leading minus
// for negatives and digits most significant first, or a single word flagged
// invalid_base when the alphabet is unusable. The back end's shared divider
// retires four quotient bits per cycle. A two-entry job queue lets the next
// numbers be accepted while one is being converted.
module signed_integer_to_radix_text
    import isrt_pkg::*;
#(
    parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEFAULT,
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    isrt_in_if.sink               request,
    isrt_out_if.source            result
);

    logic [BASE_W-1:0]     base_length_reg;
    logic [63:0]           alphabet_low_reg;
    logic [63:0]           alphabet_high_reg;
    logic                  cfg_write;
    reg_index_t            cfg_index;
    cfg_t                  cfg;

    logic                    push_valid, push_ready;
    logic [NUMBER_WIDTH+1:0] push_data;
    logic                    pop_valid, pop_ready;
    logic [NUMBER_WIDTH+1:0] pop_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg   <= '0;
            alphabet_low_reg  <= '0;
            alphabet_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BASE_LENGTH:   base_length_reg   <= pwdata[BASE_W-1:0];
                REG_ALPHABET_LOW:  alphabet_low_reg  <= pwdata;
                REG_ALPHABET_HIGH: alphabet_high_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_BASE_LENGTH:   prdata = APB_DATA_W'(base_length_reg);
            REG_ALPHABET_LOW:  prdata = alphabet_low_reg;
            REG_ALPHABET_HIGH: prdata = alphabet_high_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg.base_length = base_length_reg;
    assign cfg.alphabet    = {alphabet_high_reg, alphabet_low_reg};

    isrt_front #(
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_front (
        .cfg        (cfg),
        .request    (request),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    isrt_queue #(
        .WIDTH (NUMBER_WIDTH + 2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    isrt_back #(
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

>>> rtl/isrt_front.sv
// ----------------------------------------------------------------------------
// isrt_front
// Accepts numbers, checks the alphabet and splits each number into sign and
// magnitude before handing it to the job queue.
// ----------------------------------------------------------------------------
module isrt_front
    import isrt_pkg::*;
#(
    parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEFAULT,
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
)
(
    input  cfg_t                  cfg,
    isrt_in_if.sink               request,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic [NUMBER_WIDTH+1:0] push_data
);

    logic                    alphabet_bad;
    logic                    negative;
    logic [NUMBER_WIDTH-1:0] magnitude;

    function automatic logic symbol_bad(input logic [7:0] c);
        logic bad;
        bad = (c < 8'd33) || (c > 8'd126);
        case (c)
            8'h2B, 8'h2D, 8'h25, 8'h2F, 8'h2A, 8'h3D, 8'h2C, 8'h2E: bad = 1'b1;
            default: ;
        endcase
        return bad;
    endfunction

    always_comb
    begin
        alphabet_bad = (cfg.base_length < BASE_W'(2)) ||
                       (cfg.base_length > BASE_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (cfg.base_length > BASE_W'(i))
            begin
                if (symbol_bad(cfg.alphabet[8*i +: 8]))
                begin
                    alphabet_bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if ((cfg.base_length > BASE_W'(j)) &&
                        (cfg.alphabet[8*j +: 8] == cfg.alphabet[8*i +: 8]))
                    begin
                        alphabet_bad = 1'b1;
                    end
                end
            end
        end
    end

    assign negative  = request.number[NUMBER_WIDTH-1];
    assign magnitude = negative ? (~request.number + 1'b1) : request.number;

    assign request.ready = push_ready;
    assign push_valid    = request.valid;
    assign push_data     = {alphabet_bad, negative, magnitude};

endmodule

>>> rtl/isrt_queue.sv
// ----------------------------------------------------------------------------
// isrt_queue
// Short first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module isrt_queue
    import isrt_pkg::*;
#(
    parameter int WIDTH = 34
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/isrt_back.sv
// ----------------------------------------------------------------------------
// isrt_back
// Divides each magnitude by the radix, stacks the digits and sends the text
// out one character per word, most significant digit first.
// ----------------------------------------------------------------------------
module isrt_back
    import isrt_pkg::*;
#(
    parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEFAULT,
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  logic [NUMBER_WIDTH+1:0] pop_data,
    isrt_out_if.source              result
);

    localparam int DIGIT_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int REM_W   = DIGIT_W + 1;
    localparam int NSTEP   = (NUMBER_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W   = NSTEP * STEP_BITS;
    localparam int STEP_CW = $clog2(NSTEP);
    localparam int CNT_W   = $clog2(NUMBER_WIDTH + 1);
    localparam int IDX_W   = $clog2(NUMBER_WIDTH);

    back_state_t          state_reg, state_next;
    logic [PAD_W-1:0]     mag_reg, mag_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [STEP_CW-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 neg_reg, neg_next;
    logic [DIGIT_W-1:0]   stack_reg [NUMBER_WIDTH];
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_symbol_reg, out_symbol_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_invalid_reg, out_invalid_next;

    logic                 out_free;
    logic                 out_load;
    logic                 push_digit;
    logic [REM_W-1:0]     radix;
    logic [PAD_W-1:0]     div_mag;
    logic [REM_W-1:0]     div_rem;
    logic                 quotient_zero;
    logic [CNT_W-1:0]     count_m1;
    logic [DIGIT_W-1:0]   top_digit;

    function automatic logic [7:0] symbol_of(input logic [ALPHABET_W-1:0] alphabet,
                                             input logic [DIGIT_W-1:0] digit);
        return alphabet[{digit, 3'b000} +: 8];
    endfunction

    assign out_free  = !out_valid_reg || result.ready;
    assign radix     = cfg.base_length[REM_W-1:0];
    assign count_m1  = count_reg - 1'b1;
    assign top_digit = stack_reg[count_m1[IDX_W-1:0]];
    assign pop_ready = (state_reg == BACK_IDLE);

    always_comb
    begin
        logic [REM_W-1:0] r;
        logic [PAD_W-1:0] m;
        r = rem_reg;
        m = mag_reg;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            r = {r[REM_W-2:0], m[PAD_W-1]};
            m = {m[PAD_W-2:0], 1'b0};
            if (r >= radix)
            begin
                r    = r - radix;
                m[0] = 1'b1;
            end
        end
        div_rem = r;
        div_mag = m;
    end

    assign quotient_zero = (div_mag == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = pop_data[NUMBER_WIDTH+1] ? BACK_INVALID : BACK_DIVIDE;
                end
            end
            BACK_INVALID:
            begin
                if (out_free)
                begin
                    state_next = BACK_IDLE;
                end
            end
            BACK_DIVIDE:
            begin
                if ((step_reg == '0) && quotient_zero)
                begin
                    state_next = neg_reg ? BACK_SIGN : BACK_EMIT;
                end
            end
            BACK_SIGN:
            begin
                if (out_free)
                begin
                    state_next = BACK_EMIT;
                end
            end
            BACK_EMIT:
            begin
                if (out_free && (count_reg == CNT_W'(1)))
                begin
                    state_next = BACK_IDLE;
                end
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    always_comb
    begin
        mag_next         = mag_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        count_next       = count_reg;
        neg_next         = neg_reg;
        push_digit       = 1'b0;
        out_load         = 1'b0;
        out_symbol_next  = out_symbol_reg;
        out_last_next    = out_last_reg;
        out_invalid_next = out_invalid_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (pop_valid)
                begin
                    mag_next   = PAD_W'(pop_data[NUMBER_WIDTH-1:0]);
                    neg_next   = pop_data[NUMBER_WIDTH];
                    rem_next   = '0;
                    step_next  = STEP_CW'(NSTEP - 1);
                    count_next = '0;
                end
            end
            BACK_INVALID:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_symbol_next  = 8'h00;
                    out_last_next    = 1'b1;
                    out_invalid_next = 1'b1;
                end
            end
            BACK_DIVIDE:
            begin
                mag_next = div_mag;
                if (step_reg == '0)
                begin
                    push_digit = 1'b1;
                    count_next = count_reg + 1'b1;
                    rem_next   = '0;
                    step_next  = STEP_CW'(NSTEP - 1);
                end
                else
                begin
                    rem_next  = div_rem;
                    step_next = step_reg - 1'b1;
                end
            end
            BACK_SIGN:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_symbol_next  = CHAR_MINUS;
                    out_last_next    = 1'b0;
                    out_invalid_next = 1'b0;
                end
            end
            BACK_EMIT:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_symbol_next  = symbol_of(cfg.alphabet, top_digit);
                    out_last_next    = (count_reg == CNT_W'(1));
                    out_invalid_next = 1'b0;
                    count_next       = count_m1;
                end
            end
            default: ;
        endcase
        out_valid_next = out_load || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg         <= mag_next;
        rem_reg         <= rem_next;
        out_symbol_reg  <= out_symbol_next;
        out_last_reg    <= out_last_next;
        out_invalid_reg <= out_invalid_next;
        if (push_digit)
        begin
            stack_reg[count_reg[IDX_W-1:0]] <= div_rem[DIGIT_W-1:0];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.symbol       = out_symbol_reg;
    assign result.last         = out_last_reg;
    assign result.invalid_base = out_invalid_reg;

endmodule

>>> rtl/isrt_checker.sv
// ----------------------------------------------------------------------------
// isrt_checker
// Port-level checks on pready and the character output of the radix text converter.
// ----------------------------------------------------------------------------
module isrt_checker
    import isrt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_symbol,
    input logic       res_last,
    input logic       res_invalid
);

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_symbol) &&
        $stable(res_last) && $stable(res_invalid))
        else $error("stalled result word changed");

    a_invalid_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_invalid |-> res_last && (res_symbol == 8'h00))
        else $error("invalid alphabet word is not a lone zero word");

    a_minus_leads: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_invalid && (res_symbol == CHAR_MINUS) |-> !res_last)
        else $error("minus sign ended a number");

endmodule

bind signed_integer_to_radix_text isrt_checker u_isrt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_symbol  (result.symbol),
    .res_last    (result.last),
    .res_invalid (result.invalid_base)
);

>>> tb/tb_signed_integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// tb_signed_integer_to_radix_text
// Self-checking testbench for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
// Numbers are sent through a valid/ready driver, and the character words that
// come back are compared with the text that a local predictor writes for each
// accepted number. The alphabet and radix are set over the register port while
// the converter is idle. A short directed part covers the extremes of the
// number range, the smallest and largest radix, unused alphabet bytes, an
// unmapped register and every kind of unusable alphabet. Random phases follow,
// each with its own random alphabet, valid or broken, and in most of them
// random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_signed_integer_to_radix_text;
    import isrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                  RANDOM_NUMBERS = 230;
    localparam int                  SETTLE_CYCLES  = 20;
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = APB_ADDR_W'(24);
    localparam string               FORBIDDEN      = "+-%/*=,.";

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       invalid_base;
    } text_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    isrt_in_if #(.NUMBER_WIDTH(32)) number_bus ();
    isrt_out_if                     text_bus ();

    logic signed [31:0] number_backlog[$];
    text_word_t         text_expected[$];

    logic [4:0]   base_cfg;
    logic [127:0] alphabet_cfg;
    bit           calm;
    int           send_gap;
    int           take_gap;
    int           failures;

    logic signed [31:0] directed_decimal[9] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10,
        32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh7FFF_FFFF
    };

    signed_integer_to_radix_text dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .request (number_bus),
        .result  (text_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    function automatic logic [APB_ADDR_W-1:0] reg_addr(input reg_index_t index);
        return {index, 3'b000};
    endfunction

    function automatic void number_bus_push(input logic signed [31:0] value);
        number_backlog.push_back(value);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit char_allowed(input logic [7:0] c);
        int k;
        if (c < 8'd33 || c > 8'd126)
            return 1'b0;
        for (k = 0; k < FORBIDDEN.len(); k++)
            if (c == FORBIDDEN[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit alphabet_usable();
        int count;
        int i;
        int j;
        count = base_cfg;
        if (count < 2 || count > 16)
            return 1'b0;
        for (i = 0; i < count; i++)
        begin
            if (!char_allowed(alphabet_cfg[i*8 +: 8]))
                return 1'b0;
            for (j = i + 1; j < count; j++)
                if (alphabet_cfg[j*8 +: 8] == alphabet_cfg[i*8 +: 8])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_text(input logic signed [31:0] value);
        text_word_t   word;
        logic [32:0]  rest;
        logic [32:0]  radix;
        logic [3:0]   digits[$];
        int           k;
        if (!alphabet_usable())
        begin
            word = '{symbol: 8'd0, last: 1'b1, invalid_base: 1'b1};
            text_expected.push_back(word);
            return;
        end
        radix = 33'(base_cfg);
        rest  = value[31] ? {1'b0, ~value} + 33'd1 : {1'b0, value};
        do
        begin
            digits.push_front(4'(rest % radix));
            rest = rest / radix;
        end
        while (rest != 0);
        if (value[31])
        begin
            word = '{symbol: CHAR_MINUS, last: 1'b0, invalid_base: 1'b0};
            text_expected.push_back(word);
        end
        for (k = 0; k < digits.size(); k++)
        begin
            word = '{symbol: alphabet_cfg[digits[k]*8 +: 8],
                     last: (k == digits.size() - 1), invalid_base: 1'b0};
            text_expected.push_back(word);
        end
    endfunction

    function automatic logic [127:0] alphabet_from(input string text);
        logic [127:0] symbols;
        int           k;
        symbols = '0;
        for (k = 0; k < text.len() && k < 16; k++)
            symbols[k*8 +: 8] = text[k];
        return symbols;
    endfunction

    function automatic logic [127:0] random_alphabet(input int count);
        logic [127:0] symbols;
        logic [7:0]   c;
        bit           taken[256];
        int           k;
        symbols = {$urandom, $urandom, $urandom, $urandom};
        for (k = 0; k < count; k++)
        begin
            do
                c = 8'($urandom_range(33, 126));
            while (!char_allowed(c) || taken[c]);
            taken[c] = 1'b1;
            symbols[k*8 +: 8] = c;
        end
        return symbols;
    endfunction

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [63:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == reg_addr(REG_BASE_LENGTH))
            base_cfg = data[4:0];
        else if (addr == reg_addr(REG_ALPHABET_LOW))
            alphabet_cfg[63:0] = data;
        else if (addr == reg_addr(REG_ALPHABET_HIGH))
            alphabet_cfg[127:64] = data;
    endtask

    task automatic configure(input int count, input logic [127:0] symbols);
        if ($urandom_range(0, 5) == 0)
            write_reg(UNMAPPED_ADDR, {$urandom, $urandom});
        write_reg(reg_addr(REG_BASE_LENGTH), {$urandom, 27'($urandom), 5'(count)});
        write_reg(reg_addr(REG_ALPHABET_LOW), symbols[63:0]);
        write_reg(reg_addr(REG_ALPHABET_HIGH), symbols[127:64]);
    endtask

    task automatic drain();
        while (number_backlog.size() != 0 || number_bus.valid || text_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_bus.valid  <= 1'b0;
            number_bus.number <= '0;
            send_gap          <= 0;
        end
        else if (!number_bus.valid || number_bus.ready)
        begin
            if (send_gap != 0)
            begin
                number_bus.valid <= 1'b0;
                send_gap         <= send_gap - 1;
            end
            else if (number_backlog.size() != 0)
            begin
                number_bus.valid  <= 1'b1;
                number_bus.number <= number_backlog.pop_front();
                send_gap          <= pick_gap();
            end
            else
            begin
                number_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && number_bus.valid && number_bus.ready)
            predict_text(number_bus.number);
    end

    always @(posedge clk or negedge rst_n)
    begin : text_monitor
        text_word_t want;
        if (!rst_n)
        begin
            text_bus.ready <= 1'b0;
            take_gap       <= 0;
        end
        else
        begin
            if (text_bus.valid && text_bus.ready)
            begin
                if (text_expected.size() == 0)
                begin
                    $error("unexpected word: symbol %0h last %0b invalid_base %0b",
                           text_bus.symbol, text_bus.last, text_bus.invalid_base);
                    failures++;
                end
                else
                begin
                    want = text_expected.pop_front();
                    if (text_bus.symbol !== want.symbol)
                    begin
                        $error("symbol: expected %0h, actual %0h", want.symbol, text_bus.symbol);
                        failures++;
                    end
                    if (text_bus.last !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, text_bus.last);
                        failures++;
                    end
                    if (text_bus.invalid_base !== want.invalid_base)
                    begin
                        $error("invalid_base: expected %0b, actual %0b",
                               want.invalid_base, text_bus.invalid_base);
                        failures++;
                    end
                end
            end
            if (take_gap != 0)
            begin
                text_bus.ready <= 1'b0;
                take_gap       <= take_gap - 1;
            end
            else
            begin
                text_bus.ready <= 1'b1;
                take_gap       <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [127:0]       symbols;
        logic [7:0]         c;
        logic signed [31:0] value;
        int                 count;
        int                 i;
        int                 j;
        int                 sent;
        int                 batch;
        int                 roll;

        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        base_cfg     = '0;
        alphabet_cfg = '0;
        calm         = 1'b0;
        failures     = 0;
        rst_n        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset alphabet is empty and therefore unusable.
        number_bus_push(32'sd5);
        drain();

        configure(10, alphabet_from("0123456789"));
        foreach (directed_decimal[k])
            number_bus_push(directed_decimal[k]);
        drain();

        configure(2, alphabet_from("!~"));
        number_bus_push(32'sd0);
        number_bus_push(-32'sd1);
        number_bus_push(32'sh7FFF_FFFF);
        number_bus_push(32'sh8000_0000);
        drain();

        configure(16, alphabet_from("0123456789ABCDEF"));
        number_bus_push(32'shDEAD_BEEF);
        number_bus_push(32'sh7FFF_FFFF);
        number_bus_push(32'sd255);
        drain();

        // Bytes past the radix are not part of the alphabet.
        write_reg(UNMAPPED_ADDR, {$urandom, $urandom});
        configure(3, alphabet_from("xyz+-,. xyz"));
        number_bus_push(-32'sd100);
        number_bus_push(32'sd8);
        drain();

        configure(1, alphabet_from("0123"));
        number_bus_push(32'sd7);
        drain();
        configure(17, alphabet_from("0123456789ABCDEF"));
        number_bus_push(32'sd7);
        drain();
        configure(31, alphabet_from("0123456789ABCDEF"));
        number_bus_push(-32'sd7);
        drain();
        configure(4, alphabet_from("0120"));
        number_bus_push(32'sd7);
        drain();
        configure(4, alphabet_from("01+2"));
        number_bus_push(32'sd7);
        drain();
        configure(3, alphabet_from("0 1"));
        number_bus_push(32'sd7);
        drain();
        symbols = alphabet_from("012");
        symbols[23:16] = 8'd127;
        configure(3, symbols);
        number_bus_push(32'sd7);
        drain();

        sent = 0;
        while (sent < RANDOM_NUMBERS)
        begin
            calm  = ($urandom_range(0, 4) == 0);
            roll  = $urandom_range(0, 99);
            count = $urandom_range(2, 16);
            if (roll < 8)
                count = 2;
            else if (roll < 16)
                count = 16;
            symbols = random_alphabet(count);
            if (roll >= 78)
            begin
                case ($urandom_range(0, 4))
                    0: count = $urandom_range(0, 1);
                    1: count = $urandom_range(17, 31);
                    2:
                    begin
                        i = $urandom_range(0, count - 2);
                        j = $urandom_range(i + 1, count - 1);
                        symbols[j*8 +: 8] = symbols[i*8 +: 8];
                    end
                    3: symbols[$urandom_range(0, count - 1)*8 +: 8] =
                           FORBIDDEN[$urandom_range(0, FORBIDDEN.len() - 1)];
                    default:
                    begin
                        c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 32))
                                                       : 8'($urandom_range(127, 255));
                        symbols[$urandom_range(0, count - 1)*8 +: 8] = c;
                    end
                endcase
            end
            configure(count, symbols);
            batch = $urandom_range(8, 30);
            for (i = 0; i < batch; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    value = $urandom;
                else if (roll < 60)
                    value = $signed($urandom_range(0, 600)) - 32'sd300;
                else if (roll < 70)
                    value = directed_decimal[$urandom_range(0, $size(directed_decimal) - 1)];
                else
                    value = $signed($urandom) >>> $urandom_range(0, 31);
                number_bus_push(value);
            end
            sent += batch;
            drain();
        end

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/isrt_pkg.sv
rtl/isrt_if.sv
rtl/isrt_front.sv
rtl/isrt_queue.sv
rtl/isrt_back.sv
rtl/signed_integer_to_radix_text.sv
rtl/isrt_checker.sv
tb/tb_signed_integer_to_radix_text.sv
